@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define AST_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion, checked during reset too
`define AST_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ hw/rtl/yin_pkg.sv @@
// ----------------------------------------------------------------------------
// yin_pkg
// types and constants of the yin pitch detector
// ----------------------------------------------------------------------------
`default_nettype none

package yin_pkg;

  localparam int SR_W = 18;
  localparam logic [SR_W-1:0] SR_RESET = 18'd48000;
  localparam int LAG_W = 10;
  localparam int NORM_DEPTH = 1024;
  localparam int NORM_W = 16;
  localparam logic [11:0] QUIET_PER_SAMPLE = 12'd2416;
  localparam logic [NORM_W-1:0] THRESH_Q = 16'd614;
  localparam logic [NORM_W-1:0] NORM_ONE = 16'd4096;
  localparam logic [NORM_W-1:0] NORM_SAT = 16'hFFFF;
  localparam int LOW_HZ_DIV = 55;
  localparam int HIGH_HZ_DIV = 1200;
  // reciprocals for the lag limits, exact over the whole rate range
  localparam logic [19:0] RECIP_55 = 20'd610081;
  localparam int RECIP_55_SH = 25;
  localparam logic [18:0] RECIP_1200 = 19'd447393;
  localparam int RECIP_1200_SH = 29;
  localparam int FREQ_W = 20;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 20'hFFFFF;
  localparam int DIV_QW = 20;
  localparam int DIV_SW = 5;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_QUIET  = 2'd1;
  localparam logic [1:0] ST_NARROW = 2'd2;
  localparam logic [1:0] ST_NODIP  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_GATE, S_LIM55, S_LIM1200, S_RANGE, S_DIFF, S_DRAIN, S_NMUL,
    S_NCHK, S_NDIV, S_NWR, S_SINIT, S_SRCH, S_PDIV, S_FCHK, S_FDIV, S_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_SW-1:0] steps;
  } div_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/yin_div.sv @@
// ----------------------------------------------------------------------------
// yin_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module yin_div #(
  parameter int NUM_W = 64,
  parameter int DSH_W = 68
) (
  input  logic                       clk,
  input  logic                       rst,
  input  yin_pkg::div_ctl_t          ctl,
  input  logic [NUM_W-1:0]           num,
  input  logic [DSH_W-1:0]           dsh,
  output logic                       done,
  output logic [yin_pkg::DIV_QW-1:0] quot
);

  logic                       busy;
  logic [yin_pkg::DIV_SW-1:0] cnt;
  logic [NUM_W-1:0]           rem;
  logic [DSH_W-1:0]           dsh_r;
  logic                       ge;

  // divisor arrives pre-shifted so that the quotient fits in steps bits
  assign ge = DSH_W'(rem) >= dsh_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == yin_pkg::DIV_SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem   <= num;
      dsh_r <= dsh;
      quot  <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - NUM_W'(dsh_r);
      end
      quot  <= {quot[yin_pkg::DIV_QW-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/yin_pitch_detector.sv @@
// start: an accepted last word starts one analysis of the loaded window
// throughput: one sample word per cycle while loading; during analysis the input
//   is stalled, the single difference MAC on the two window read ports sets the pace
// reset: synchronous, clears counts, sums and handshakes, the rate register to 48000;
//   window and norm memories are not cleared
// ----------------------------------------------------------------------------
// yin_pitch_detector
// windowed yin pitch detector with one MAC unit and a shared serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module yin_pitch_detector #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [yin_pkg::SR_W-1:0]     cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           sample,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [15:0]                  period_lag,
  output logic [yin_pkg::FREQ_W-1:0]   freq_hz
);

  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int CW      = $clog2(MAX_WINDOW + 1);
  localparam int EN_W    = 30 + CW;
  localparam int ACC_W   = 32 + AW;
  localparam int LW      = yin_pkg::LAG_W;
  localparam int TOT_W   = ACC_W + LW;
  localparam int DNUM_W  = TOT_W + 12;
  localparam int DDSH_W  = TOT_W + 16;
  localparam int NA_W    = $clog2(yin_pkg::NORM_DEPTH);

  yin_pkg::state_t state, state_next;

  logic [yin_pkg::SR_W-1:0] fs_hz;
  logic [CW-1:0]            count;
  logic [EN_W-1:0]          energy;
  logic [CW-1:0]            nlen;

  // memories
  logic signed [15:0]           wmem [MAX_WINDOW];
  logic [yin_pkg::NORM_W-1:0]   nmem [yin_pkg::NORM_DEPTH];

  // lag limits
  logic [13:0]   q55;
  logic [LW-1:0] tmin_r, tmax;
  logic [38:0]   lim55_p;
  logic [36:0]   lim1200_p;
  logic [7:0]    t1200;

  // difference loop
  logic [LW-1:0]      tau;
  logic [CW-1:0]      j, jlim, jb;
  logic               issue, v1, v2;
  logic signed [15:0] ra, rb;
  logic signed [16:0] dif;
  logic signed [33:0] dsq;
  logic [31:0]        sq;
  logic [ACC_W-1:0]   acc;
  logic [TOT_W-1:0]   total, prod;
  logic [15:0]        nval;

  // dip search
  logic [LW-1:0] addr, ctau;
  logic          issue_n, rv;
  logic [15:0]   rdn, y0, y1, y2;
  logic [1:0]    fill;
  logic          dip, at_end;
  logic [17:0]   den;
  logic [15:0]   mag_d;
  logic [22:0]   pnum;
  logic          neg;

  // period and frequency
  logic [15:0]               per;
  logic [28:0]               fnum;
  logic                      fsat;
  logic [1:0]                res_status;
  logic [15:0]               res_per;
  logic [yin_pkg::FREQ_W-1:0] res_freq;

  // input side
  logic               accept, store, quiet, emit_load;
  logic signed [31:0] s_sq;
  logic [CW+11:0]     qthr;

  // range check
  logic signed [15:0] tm_a, tm_b, tmax_s, tmin_s;
  logic               narrow, tot_zero, nsat;

  // divider
  yin_pkg::div_ctl_t          div_ctl;
  logic [DNUM_W-1:0]          div_num;
  logic [DDSH_W-1:0]          div_dsh;
  logic                       div_done;
  logic [yin_pkg::DIV_QW-1:0] dq;

  yin_div #(.NUM_W(DNUM_W), .DSH_W(DDSH_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  (div_num),
    .dsh  (div_dsh),
    .done (div_done),
    .quot (dq)
  );

  assign accept = in_valid && !in_stall;
  assign store  = count < CW'(MAX_WINDOW);
  assign s_sq   = sample * sample;
  assign qthr   = count * yin_pkg::QUIET_PER_SAMPLE;
  assign quiet  = energy < EN_W'(qthr);

  // constant divisions by 55 and 1200 as reciprocal multiplies
  assign lim55_p   = 39'({fs_hz, 1'b0}) * 39'(yin_pkg::RECIP_55);
  assign lim1200_p = 37'(fs_hz) * 37'(yin_pkg::RECIP_1200);
  assign t1200     = lim1200_p[yin_pkg::RECIP_1200_SH +: 8];

  assign tm_a   = $signed(16'(nlen >> 1)) - 16'sd2;
  assign tm_b   = $signed({2'b00, q55});
  assign tmax_s = (tm_b < tm_a) ? tm_b : tm_a;
  assign tmin_s = $signed(16'(tmin_r));
  assign narrow = tmax_s <= (tmin_s + 16'sd8);

  assign jlim  = nlen - CW'(tau);
  assign jb    = j + CW'(tau);
  assign issue = (state == yin_pkg::S_DIFF) && (j < jlim);
  assign dif   = {ra[15], ra} - {rb[15], rb};
  assign dsq   = dif * dif;

  assign tot_zero = total == '0;
  assign nsat     = prod >= {total, 4'b0};

  assign issue_n = (state == yin_pkg::S_SRCH) && (addr < tmax);
  assign dip     = (fill == 2'd3) && (y1 < yin_pkg::THRESH_Q) && (y1 < y0) && (y1 < y2);
  assign at_end  = ctau == (tmax - LW'(2));
  assign den     = 18'(y0) + 18'(y2) - {1'b0, y1, 1'b0};
  assign neg     = y0 < y2;
  assign mag_d   = neg ? (y2 - y0) : (y0 - y2);
  assign pnum    = {1'b0, mag_d, 6'b0} + 23'(den);

  assign fnum = {1'b0, fs_hz, 10'b0} + 29'(per >> 1);
  assign fsat = 36'(fnum) >= {per, 20'b0};

  assign emit_load = (state == yin_pkg::S_EMIT) && (!out_valid || !out_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      yin_pkg::S_IDLE:    if (accept && last) state_next = yin_pkg::S_GATE;
      yin_pkg::S_GATE:    state_next = quiet ? yin_pkg::S_EMIT : yin_pkg::S_LIM55;
      yin_pkg::S_LIM55:   state_next = yin_pkg::S_LIM1200;
      yin_pkg::S_LIM1200: state_next = yin_pkg::S_RANGE;
      yin_pkg::S_RANGE:   state_next = narrow ? yin_pkg::S_EMIT : yin_pkg::S_DIFF;
      yin_pkg::S_DIFF:    if (!issue) state_next = yin_pkg::S_DRAIN;
      yin_pkg::S_DRAIN:   if (!v1 && !v2) state_next = yin_pkg::S_NMUL;
      yin_pkg::S_NMUL:    state_next = yin_pkg::S_NCHK;
      yin_pkg::S_NCHK:    state_next = (tot_zero || nsat) ? yin_pkg::S_NWR : yin_pkg::S_NDIV;
      yin_pkg::S_NDIV:    if (div_done) state_next = yin_pkg::S_NWR;
      yin_pkg::S_NWR:     state_next = ((tau + 1'b1) < tmax) ? yin_pkg::S_DIFF : yin_pkg::S_SINIT;
      yin_pkg::S_SINIT:   state_next = yin_pkg::S_SRCH;
      yin_pkg::S_SRCH: begin
        if (dip) state_next = yin_pkg::S_PDIV;
        else if (fill == 2'd3 && at_end) state_next = yin_pkg::S_EMIT;
      end
      yin_pkg::S_PDIV:    if (div_done) state_next = yin_pkg::S_FCHK;
      yin_pkg::S_FCHK:    state_next = fsat ? yin_pkg::S_EMIT : yin_pkg::S_FDIV;
      yin_pkg::S_FDIV:    if (div_done) state_next = yin_pkg::S_EMIT;
      yin_pkg::S_EMIT:    if (emit_load) state_next = yin_pkg::S_IDLE;
      default:            state_next = yin_pkg::S_IDLE;
    endcase
  end

  // outputs: stall and divider launch with its operands
  always_comb begin
    in_stall      = state != yin_pkg::S_IDLE;
    div_ctl.start = 1'b0;
    div_ctl.steps = '0;
    div_num       = '0;
    div_dsh       = '0;
    case (state)
      yin_pkg::S_NCHK: begin
        div_ctl.start = !tot_zero && !nsat;
        div_ctl.steps = yin_pkg::DIV_SW'(16);
        div_num       = {prod, 12'b0};
        div_dsh       = DDSH_W'({total, 15'b0});
      end
      yin_pkg::S_SRCH: begin
        div_ctl.start = dip;
        div_ctl.steps = yin_pkg::DIV_SW'(7);
        div_num       = DNUM_W'(pnum);
        div_dsh       = DDSH_W'({den, 7'b0});
      end
      yin_pkg::S_FCHK: begin
        div_ctl.start = !fsat;
        div_ctl.steps = yin_pkg::DIV_SW'(20);
        div_num       = DNUM_W'(fnum);
        div_dsh       = DDSH_W'({per, 19'b0});
      end
      default: begin
        div_ctl.start = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= yin_pkg::S_IDLE;
      fs_hz     <= yin_pkg::SR_RESET;
      count     <= '0;
      energy    <= '0;
      out_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      rv        <= 1'b0;
      fill      <= '0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      rv    <= issue_n;
      if (cfg_we) begin
        fs_hz <= cfg_wdata;
      end
      if (accept && store) begin
        count  <= count + 1'b1;
        energy <= energy + EN_W'(s_sq[30:0]);
      end
      if (state == yin_pkg::S_GATE) begin
        count  <= '0;
        energy <= '0;
      end
      if (state == yin_pkg::S_SINIT) begin
        fill <= '0;
      end else if (state == yin_pkg::S_SRCH && rv && !dip && fill != 2'd3) begin
        fill <= fill + 1'b1;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && store) begin
      wmem[count[AW-1:0]] <= sample;
    end
    ra <= wmem[j[AW-1:0]];
    rb <= wmem[jb[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == yin_pkg::S_NWR) begin
      nmem[NA_W'(tau)] <= nval;
    end
    rdn <= nmem[NA_W'(addr)];
  end

  // datapath
  always_ff @(posedge clk) begin
    sq <= dsq[31:0];
    case (state)
      yin_pkg::S_GATE: begin
        nlen       <= count;
        res_per    <= '0;
        res_freq   <= '0;
        res_status <= yin_pkg::ST_QUIET;
      end
      yin_pkg::S_LIM55: begin
        q55 <= lim55_p[yin_pkg::RECIP_55_SH +: 14];
      end
      yin_pkg::S_LIM1200: begin
        tmin_r <= (t1200 < 8'd3) ? LW'(3) : LW'(t1200);
      end
      yin_pkg::S_RANGE: begin
        tmax       <= LW'(tmax_s);
        tau        <= LW'(1);
        j          <= '0;
        acc        <= '0;
        total      <= '0;
        res_status <= yin_pkg::ST_NARROW;
      end
      yin_pkg::S_DIFF: begin
        if (issue) j <= j + 1'b1;
      end
      yin_pkg::S_NMUL: begin
        total <= total + TOT_W'(acc);
        prod  <= acc * tau;
      end
      yin_pkg::S_NCHK: begin
        if (tot_zero) nval <= yin_pkg::NORM_ONE;
        else if (nsat) nval <= yin_pkg::NORM_SAT;
      end
      yin_pkg::S_NDIV: begin
        if (div_done) nval <= dq[15:0];
      end
      yin_pkg::S_NWR: begin
        tau <= tau + 1'b1;
        j   <= '0;
        acc <= '0;
      end
      yin_pkg::S_SINIT: begin
        addr       <= tmin_r - LW'(1);
        ctau       <= tmin_r - LW'(3);
        res_status <= yin_pkg::ST_NODIP;
      end
      yin_pkg::S_SRCH: begin
        if (issue_n) addr <= addr + 1'b1;
        // slide the three-tap window unless a dip holds it
        if (rv && !dip) begin
          y0   <= y1;
          y1   <= y2;
          y2   <= rdn;
          ctau <= ctau + 1'b1;
        end
      end
      yin_pkg::S_PDIV: begin
        if (div_done) begin
          per <= neg ? ({ctau, 6'b0} - 16'(dq[5:0])) : ({ctau, 6'b0} + 16'(dq[5:0]));
        end
      end
      yin_pkg::S_FCHK: begin
        res_per    <= per;
        res_status <= yin_pkg::ST_FOUND;
        if (fsat) res_freq <= yin_pkg::FREQ_MAX;
      end
      yin_pkg::S_FDIV: begin
        if (div_done) res_freq <= dq;
      end
      default: begin
        nval <= nval;
      end
    endcase
    if (v2) begin
      acc <= acc + ACC_W'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      status     <= res_status;
      period_lag <= res_per;
      freq_hz    <= res_freq;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/yin_chk.sv @@
// ----------------------------------------------------------------------------
// yin_chk
// port-level checks of the yin pitch detector
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module yin_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 status,
  input logic [15:0]                period_lag,
  input logic [yin_pkg::FREQ_W-1:0] freq_hz
);

  // a closing word starts analysis, so input stalls next cycle
  `AST_CLK_RST(a_last_stalls, clk, rst, in_valid && !in_stall && last |=> in_stall)

  // no pitch means zero period and frequency
  `AST_CLK_RST(a_zero_unless_found, clk, rst,
    out_valid && (status != yin_pkg::ST_FOUND) |-> (period_lag == 16'd0) && (freq_hz == '0))

  // a found pitch has a nonzero period
  `AST_CLK_RST(a_found_period, clk, rst,
    out_valid && (status == yin_pkg::ST_FOUND) |-> period_lag != 16'd0)

  // a stalled result word stays offered
  `AST_CLK_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)

endmodule

bind yin_pitch_detector yin_chk u_chk (.*);

`default_nettype wire
